// ----- hw/rtl/rdt_pkg.sv -----
// Shared types and codes for the reload down-timer block.
package rdt_pkg;

  localparam int unsigned TickWidth = 24;

  typedef logic [2:0] rdt_cmd_t;
  localparam rdt_cmd_t CMD_TICK         = 3'd0;
  localparam rdt_cmd_t CMD_START_SINGLE = 3'd1;
  localparam rdt_cmd_t CMD_START_PERIOD = 3'd2;
  localparam rdt_cmd_t CMD_STOP         = 3'd3;
  localparam rdt_cmd_t CMD_BUSY_WAIT    = 3'd4;
  localparam rdt_cmd_t CMD_READ_ELAPSED = 3'd5;
  localparam rdt_cmd_t CMD_READ_REMAIN  = 3'd6;

  typedef logic [1:0] rdt_kind_t;
  localparam rdt_kind_t KIND_STATUS    = 2'd0;
  localparam rdt_kind_t KIND_READ      = 2'd1;
  localparam rdt_kind_t KIND_FIRE      = 2'd2;
  localparam rdt_kind_t KIND_WAIT_DONE = 2'd3;

  typedef logic [1:0] rdt_status_t;
  localparam rdt_status_t ST_OK         = 2'd0;
  localparam rdt_status_t ST_RANGE      = 2'd1;
  localparam rdt_status_t ST_BUSY       = 2'd2;
  localparam rdt_status_t ST_NO_HANDLER = 2'd3;

  typedef logic [1:0] rdt_cfg_idx_t;
  localparam rdt_cfg_idx_t CFG_DIV_BY_EIGHT = 2'd0;
  localparam rdt_cfg_idx_t CFG_IRQ_ENABLE   = 2'd1;
  localparam rdt_cfg_idx_t CFG_TIMER_ENABLE = 2'd2;

  typedef struct packed {
    rdt_cmd_t              command;
    logic [TickWidth-1:0]  tick_count;
    logic                  handler_present;
  } rdt_in_t;

  typedef struct packed {
    rdt_kind_t             result_kind;
    rdt_status_t           status_code;
    logic [TickWidth-1:0]  time_value;
  } rdt_out_t;

  typedef struct packed {
    logic         wr;
    rdt_cfg_idx_t index;
    logic         data;
  } rdt_cfg_wr_t;

endpackage

// ----- hw/rtl/rdt_in_stage.sv -----
// Input register: holds one accepted item until the engine takes it.
module rdt_in_stage (
  input  logic            clk,
  input  logic            rst,
  input  logic            item_valid,
  input  rdt_pkg::rdt_in_t item,
  input  logic            take,
  output logic            item_stall,
  output logic            held_valid,
  output rdt_pkg::rdt_in_t held
);
  import rdt_pkg::*;

  assign item_stall = held_valid && !take;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (!item_stall) begin
      held_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!item_stall) begin
      held <= item;
    end
  end

endmodule

// ----- hw/rtl/rdt_engine.sv -----
// Timer state and the per-word command decode that produces at most one result.
module rdt_engine #(
  parameter int unsigned COUNTER_WIDTH = 24
) (
  input  logic                clk,
  input  logic                rst,
  input  rdt_pkg::rdt_cfg_wr_t cfg,
  input  logic                go,
  input  rdt_pkg::rdt_in_t     cmd,
  output logic                res_valid,
  output rdt_pkg::rdt_out_t    res
);
  import rdt_pkg::*;

  localparam int unsigned W = COUNTER_WIDTH;
  localparam logic [32:0] MaxTicks = (33'd1 << W) - 33'd1;

  logic [W-1:0] reload, reload_next;
  logic [W-1:0] count, count_next;
  logic         div8, div8_next;
  logic         en, en_next;
  logic         ie, ie_next;
  logic         flag, flag_next;
  logic         busy, busy_next;
  logic         periodic, periodic_next;
  logic         handler_reg, handler_reg_next;
  logic         waiting, waiting_next;
  logic [2:0]   ps, ps_next;

  logic         cclk;
  logic         evt;
  logic         ticks_oor;
  logic [32:0]  ticks_ext;
  logic [32:0]  value_ext;

  assign ticks_ext = 33'(cmd.tick_count);
  assign ticks_oor = ticks_ext >= MaxTicks;

  always_comb begin
    reload_next      = reload;
    count_next       = count;
    div8_next        = div8;
    en_next          = en;
    ie_next          = ie;
    flag_next        = flag;
    busy_next        = busy;
    periodic_next    = periodic;
    handler_reg_next = handler_reg;
    waiting_next     = waiting;
    ps_next          = ps;
    cclk             = 1'b0;
    evt              = 1'b0;
    value_ext        = '0;
    res_valid        = 1'b0;
    res              = '0;

    if (cfg.wr) begin
      unique case (cfg.index)
        CFG_DIV_BY_EIGHT: div8_next = cfg.data;
        CFG_IRQ_ENABLE:   ie_next   = cfg.data;
        CFG_TIMER_ENABLE: en_next   = cfg.data;
        default: ;
      endcase
    end

    if (go) begin
      unique case (cmd.command)
        CMD_TICK: begin
          if (en) begin
            if (div8) begin
              ps_next = ps + 3'd1;
              cclk    = (ps_next == 3'd0);
            end else begin
              cclk = 1'b1;
            end
            if (cclk) begin
              if (count == '0) begin
                count_next = reload;
              end else begin
                count_next = count - W'(1);
                if (count_next == '0) begin
                  flag_next = 1'b1;
                  evt       = 1'b1;
                end
              end
            end
            if (waiting) begin
              // wait completes on the first tick that sees the flag
              if (flag_next) begin
                reload_next        = '0;
                en_next            = 1'b0;
                flag_next          = 1'b0;
                waiting_next       = 1'b0;
                res_valid          = 1'b1;
                res.result_kind    = KIND_WAIT_DONE;
              end
            end else if (evt && ie) begin
              if (!periodic) begin
                reload_next = '0;
                ie_next     = 1'b0;
                en_next     = 1'b0;
              end
              busy_next = 1'b0;
              flag_next = 1'b0;
              if (handler_reg) begin
                res_valid       = 1'b1;
                res.result_kind = KIND_FIRE;
              end
            end
          end
        end
        CMD_START_SINGLE, CMD_START_PERIOD: begin
          if (!waiting) begin
            res_valid       = 1'b1;
            res.result_kind = KIND_STATUS;
            if (!cmd.handler_present) begin
              res.status_code = ST_NO_HANDLER;
            end else if (ticks_oor) begin
              res.status_code = ST_RANGE;
            end else if (busy) begin
              res.status_code = ST_BUSY;
            end else begin
              res.status_code  = ST_OK;
              busy_next        = 1'b1;
              periodic_next    = (cmd.command == CMD_START_PERIOD);
              ie_next          = 1'b1;
              handler_reg_next = 1'b1;
              reload_next      = ticks_ext[W-1:0];
              en_next          = 1'b1;
              flag_next        = 1'b0;
            end
          end
        end
        CMD_STOP: begin
          // busy stays set
          reload_next     = '0;
          ie_next         = 1'b0;
          en_next         = 1'b0;
          flag_next       = 1'b0;
          waiting_next    = 1'b0;
          res_valid       = 1'b1;
          res.result_kind = KIND_STATUS;
          res.status_code = ST_OK;
        end
        CMD_BUSY_WAIT: begin
          if (!waiting) begin
            if (ticks_oor) begin
              res_valid       = 1'b1;
              res.result_kind = KIND_WAIT_DONE;
              res.status_code = ST_RANGE;
            end else begin
              reload_next  = ticks_ext[W-1:0];
              en_next      = 1'b1;
              flag_next    = 1'b0;
              waiting_next = 1'b1;
            end
          end
        end
        CMD_READ_ELAPSED: begin
          value_ext       = 33'(reload - count);
          res_valid       = 1'b1;
          res.result_kind = KIND_READ;
          res.time_value  = value_ext[TickWidth-1:0];
        end
        CMD_READ_REMAIN: begin
          value_ext       = 33'(count);
          res_valid       = 1'b1;
          res.result_kind = KIND_READ;
          res.time_value  = value_ext[TickWidth-1:0];
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      reload      <= '0;
      count       <= '0;
      div8        <= 1'b1;
      en          <= 1'b0;
      ie          <= 1'b0;
      flag        <= 1'b0;
      busy        <= 1'b0;
      periodic    <= 1'b0;
      handler_reg <= 1'b0;
      waiting     <= 1'b0;
      ps          <= 3'd0;
    end else begin
      reload      <= reload_next;
      count       <= count_next;
      div8        <= div8_next;
      en          <= en_next;
      ie          <= ie_next;
      flag        <= flag_next;
      busy        <= busy_next;
      periodic    <= periodic_next;
      handler_reg <= handler_reg_next;
      waiting     <= waiting_next;
      ps          <= ps_next;
    end
  end

endmodule

// ----- hw/rtl/rdt_out_stage.sv -----
// Result register: one word toward the consumer, refilled as it drains.
module rdt_out_stage (
  input  logic             clk,
  input  logic             rst,
  input  logic             load,
  input  logic             load_valid,
  input  rdt_pkg::rdt_out_t load_data,
  input  logic             result_stall,
  output logic             result_valid,
  output rdt_pkg::rdt_out_t result
);
  import rdt_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (load) begin
      result_valid <= load_valid;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result <= load_data;
    end
  end

endmodule

// ----- hw/rtl/reload_down_timer_with_modes_core.sv -----
// Top level of the reload down-timer: input register, engine, result register.
// Takes one command word per cycle unless the input is stalled, and returns at most
// one result word for it; the word passes through the input register, the single-pass
// engine and the result register, and the result word is registered. The input
// stalls only while the result register holds a stalled word and another command
// word is waiting in the input register behind it. Config writes are accepted every
// cycle (cfg_ready is tied high).
module reload_down_timer_with_modes_core #(
  parameter int unsigned COUNTER_WIDTH = 24
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  item_valid,
  output logic                  item_stall,
  input  rdt_pkg::rdt_in_t      item,
  output logic                  result_valid,
  input  logic                  result_stall,
  output rdt_pkg::rdt_out_t     result,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  rdt_pkg::rdt_cfg_idx_t cfg_index,
  input  logic                  cfg_data
);
  import rdt_pkg::*;

  logic        held_valid;
  rdt_in_t     held;
  logic        advance;
  logic        res_valid;
  rdt_out_t    res;
  rdt_cfg_wr_t cfg;

  assign cfg_ready = 1'b1;
  assign cfg.wr    = cfg_valid && cfg_ready;
  assign cfg.index = cfg_index;
  assign cfg.data  = cfg_data;

  // engine runs on the held word once the result register can take its answer
  assign advance = held_valid && (!result_valid || !result_stall);

  rdt_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item       (item),
    .take       (advance),
    .item_stall (item_stall),
    .held_valid (held_valid),
    .held       (held)
  );

  rdt_engine #(
    .COUNTER_WIDTH (COUNTER_WIDTH)
  ) u_engine (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .go        (advance),
    .cmd       (held),
    .res_valid (res_valid),
    .res       (res)
  );

  rdt_out_stage u_out (
    .clk          (clk),
    .rst          (rst),
    .load         (advance),
    .load_valid   (res_valid),
    .load_data    (res),
    .result_stall (result_stall),
    .result_valid (result_valid),
    .result       (result)
  );

endmodule

// ----- hw/rtl/rdt_checker.sv -----
// Port-level checks for the reload down-timer, bound to the top level.
module rdt_checker (
  input logic                  clk,
  input logic                  rst,
  input logic                  item_valid,
  input logic                  item_stall,
  input rdt_pkg::rdt_in_t      item,
  input logic                  result_valid,
  input logic                  result_stall,
  input rdt_pkg::rdt_out_t     result
);
  import rdt_pkg::*;

  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result))
    else $error("stalled result word changed");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    item_stall |-> result_valid && result_stall)
    else $error("input stalled with no backed-up result");

  a_read_answer: assert property (@(posedge clk) disable iff (rst)
    (item_valid && !item_stall &&
     (item.command == CMD_READ_ELAPSED || item.command == CMD_READ_REMAIN))
    ##1 !result_stall |=> result_valid && result.result_kind == KIND_READ)
    else $error("read word gave no read data");

  a_stop_answer: assert property (@(posedge clk) disable iff (rst)
    (item_valid && !item_stall && item.command == CMD_STOP) ##1 !result_stall
    |=> result_valid && result.result_kind == KIND_STATUS &&
        result.status_code == ST_OK)
    else $error("stop word gave no ok status");

endmodule

bind reload_down_timer_with_modes_core rdt_checker u_rdt_checker (
  .clk          (clk),
  .rst          (rst),
  .item_valid   (item_valid),
  .item_stall   (item_stall),
  .item         (item),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .result       (result)
);

// ----- bench/reload_down_timer_with_modes_core_tb.sv -----
// Self-checking testbench for the reload down-timer core, with its own timer predictor.
module reload_down_timer_with_modes_core_tb;
  import rdt_pkg::*;

  localparam rdt_cfg_idx_t CFG_SPARE = 2'd3;  // index with no register behind it
  localparam logic [TickWidth-1:0] TICK_MAX = '1;  // first out-of-range count
  localparam int WORD_TARGET = 1700;
  localparam int CYCLE_LIMIT = 500000;
  localparam int TAIL_CYCLES = 6;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic item_valid = 1'b0;
  logic item_stall;
  rdt_in_t item = '0;
  logic result_valid;
  logic result_stall = 1'b0;
  rdt_out_t result;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  rdt_cfg_idx_t cfg_index = CFG_DIV_BY_EIGHT;
  logic cfg_data = 1'b0;

  reload_down_timer_with_modes_core u_dut (
    .clk(clk),
    .rst(rst),
    .item_valid(item_valid),
    .item_stall(item_stall),
    .item(item),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result(result),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // predicted timer state
  logic cf_div8, cf_irq_init, cf_run_init;
  logic [TickWidth-1:0] tm_reload, tm_count;
  logic tm_run, tm_irq, tm_flag, tm_busy, tm_periodic, tm_has_handler, tm_waiting;
  logic [2:0] tm_prescale;
  rdt_out_t pending_results[$];

  int live_words = 0;
  int words_sent = 0;
  int results_seen = 0;
  int fires_seen = 0;
  int waits_seen = 0;
  int cfg_writes = 0;
  int err_count = 0;
  int cycle_count = 0;
  int stall_mode = 0;
  int stall_left = 0;
  int burst_left = 0;
  bit gaps_on = 1'b0;
  bit cur_div8 = 1'b1;

  function automatic logic [TickWidth-1:0] rand_ticks();
    return TickWidth'($urandom);
  endfunction

  function automatic logic rand_bit();
    return 1'($urandom_range(0, 1));
  endfunction

  function automatic void expect_result(rdt_kind_t kind, rdt_status_t st,
                                        logic [TickWidth-1:0] val);
    rdt_out_t r;
    r.result_kind = kind;
    r.status_code = st;
    r.time_value = val;
    pending_results.push_back(r);
  endfunction

  function automatic void model_reset();
    cf_div8 = 1'b1;
    cf_irq_init = 1'b0;
    cf_run_init = 1'b0;
    tm_reload = '0;
    tm_count = '0;
    tm_run = cf_run_init;
    tm_irq = cf_irq_init;
    tm_flag = 1'b0;
    tm_busy = 1'b0;
    tm_periodic = 1'b0;
    tm_has_handler = 1'b0;
    tm_waiting = 1'b0;
    tm_prescale = '0;
    pending_results.delete();
  endfunction

  function automatic void model_config(rdt_cfg_idx_t idx, logic d);
    case (idx)
      CFG_DIV_BY_EIGHT: cf_div8 = d;
      CFG_IRQ_ENABLE: begin
        cf_irq_init = d;
        tm_irq = d;
      end
      CFG_TIMER_ENABLE: begin
        cf_run_init = d;
        tm_run = d;
      end
      default: ;
    endcase
  endfunction

  // Advances the predicted timer by one command word; returns 0 if the word is ignored.
  function automatic bit timer_model_step(rdt_in_t w);
    bit live;
    logic cclk, hit_zero;
    rdt_status_t st;
    live = 1'b1;
    cclk = 1'b1;
    hit_zero = 1'b0;
    case (w.command)
      CMD_TICK: begin
        if (!tm_run) begin
          live = 1'b0;
        end else begin
          if (cf_div8) begin
            tm_prescale = tm_prescale + 3'd1;
            cclk = (tm_prescale == 3'd0);
          end
          if (cclk) begin
            if (tm_count == '0) begin
              tm_count = tm_reload;
            end else begin
              tm_count = tm_count - 1'b1;
              if (tm_count == '0) begin
                tm_flag = 1'b1;
                hit_zero = 1'b1;
              end
            end
          end
          if (tm_waiting) begin
            if (tm_flag) begin
              tm_reload = '0;
              tm_run = 1'b0;
              tm_flag = 1'b0;
              tm_waiting = 1'b0;
              expect_result(KIND_WAIT_DONE, ST_OK, '0);
            end
          end else if (hit_zero && tm_irq) begin
            // handler step; single shot also shuts the timer down
            if (!tm_periodic) begin
              tm_reload = '0;
              tm_irq = 1'b0;
              tm_run = 1'b0;
            end
            tm_busy = 1'b0;
            tm_flag = 1'b0;
            if (tm_has_handler) expect_result(KIND_FIRE, ST_OK, '0);
          end
        end
      end
      CMD_START_SINGLE, CMD_START_PERIOD: begin
        if (tm_waiting) begin
          live = 1'b0;
        end else begin
          if (!w.handler_present) st = ST_NO_HANDLER;
          else if (w.tick_count == TICK_MAX) st = ST_RANGE;
          else if (tm_busy) st = ST_BUSY;
          else begin
            st = ST_OK;
            tm_busy = 1'b1;
            tm_periodic = (w.command == CMD_START_PERIOD);
            tm_irq = 1'b1;
            tm_has_handler = 1'b1;
            tm_reload = w.tick_count;
            tm_run = 1'b1;
            tm_flag = 1'b0;
          end
          expect_result(KIND_STATUS, st, '0);
        end
      end
      CMD_STOP: begin
        // busy is left set on purpose
        tm_reload = '0;
        tm_irq = 1'b0;
        tm_run = 1'b0;
        tm_flag = 1'b0;
        tm_waiting = 1'b0;
        expect_result(KIND_STATUS, ST_OK, '0);
      end
      CMD_BUSY_WAIT: begin
        if (tm_waiting) begin
          live = 1'b0;
        end else if (w.tick_count == TICK_MAX) begin
          expect_result(KIND_WAIT_DONE, ST_RANGE, '0);
        end else begin
          tm_reload = w.tick_count;
          tm_run = 1'b1;
          tm_flag = 1'b0;
          tm_waiting = 1'b1;
        end
      end
      CMD_READ_ELAPSED: expect_result(KIND_READ, ST_OK, tm_reload - tm_count);
      CMD_READ_REMAIN: expect_result(KIND_READ, ST_OK, tm_count);
      default: live = 1'b0;
    endcase
    return live;
  endfunction

  // Scoreboard: results are checked before this edge's new word is predicted.
  always @(posedge clk) begin : scoreboard
    rdt_out_t want;
    if (rst) begin
      model_reset();
    end else begin
      if (result_valid && !result_stall) begin
        results_seen++;
        if (result.result_kind == KIND_FIRE) fires_seen++;
        if (result.result_kind == KIND_WAIT_DONE) waits_seen++;
        if (pending_results.size() == 0) begin
          err_count++;
          $display("%0t: unexpected word, expected none, got kind %0d status %0d time %h",
                   $time, result.result_kind, result.status_code, result.time_value);
        end else begin
          want = pending_results.pop_front();
          if (result.result_kind !== want.result_kind ||
              result.status_code !== want.status_code ||
              result.time_value !== want.time_value) begin
            err_count++;
            $display("%0t: mismatch, expected kind %0d status %0d time %h, got kind %0d status %0d time %h",
                     $time, want.result_kind, want.status_code, want.time_value,
                     result.result_kind, result.status_code, result.time_value);
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        cfg_writes++;
        model_config(cfg_index, cfg_data);
      end
      if (item_valid && !item_stall) begin
        if (timer_model_step(item)) live_words++;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, pending_results.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Receiver back-pressure: switches between free, light, heavy and square-wave stalls.
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_left <= $urandom_range(50, 300);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      0: result_stall <= 1'b0;
      1: result_stall <= ($urandom_range(0, 3) == 0);
      2: result_stall <= ($urandom_range(0, 9) < 7);
      default: result_stall <= (cycle_count[3:2] == 2'b11);
    endcase
  end

  task automatic send_word(input rdt_cmd_t cmd, input logic [TickWidth-1:0] ticks,
                           input logic hp);
    rdt_in_t w;
    w.command = cmd;
    w.tick_count = ticks;
    w.handler_present = hp;
    item <= w;
    item_valid <= 1'b1;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    words_sent++;
    if (gaps_on) begin
      if (burst_left == 0) begin
        item_valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
        burst_left = $urandom_range(1, 12);
      end else begin
        burst_left--;
      end
    end
  endtask

  // Drain: wait until nothing is expected, then idle so the pipeline clears.
  task automatic settle();
    item_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  task automatic set_config(input logic div8, input logic irq, input logic run,
                            input bit spare);
    rdt_cfg_idx_t idx[4];
    logic val[4];
    int n;
    idx[0] = CFG_DIV_BY_EIGHT;
    val[0] = div8;
    idx[1] = CFG_IRQ_ENABLE;
    val[1] = irq;
    idx[2] = CFG_TIMER_ENABLE;
    val[2] = run;
    idx[3] = CFG_SPARE;
    val[3] = rand_bit();
    n = spare ? 4 : 3;
    settle();
    cfg_valid <= 1'b1;
    for (int i = 0; i < n; i++) begin
      cfg_index <= idx[i];
      cfg_data <= val[i];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
    end
    cfg_valid <= 1'b0;
    cur_div8 = div8;
  endtask

  task automatic tick_run(input int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 7) == 0)
        send_word(rand_bit() ? CMD_READ_ELAPSED : CMD_READ_REMAIN, rand_ticks(), rand_bit());
      send_word(CMD_TICK, rand_ticks(), rand_bit());
    end
  endtask

  task automatic test_reset_state();
    send_word(CMD_READ_REMAIN, '0, 1'b0);
    send_word(CMD_READ_ELAPSED, TICK_MAX, 1'b1);
    send_word(CMD_TICK, '0, 1'b0);  // counter disabled out of reset
  endtask

  task automatic test_directed_modes();
    set_config(1'b0, 1'b0, 1'b0, 1'b1);
    // rejections: handler first, then range, then busy
    send_word(CMD_START_SINGLE, 24'd5, 1'b0);
    send_word(CMD_START_SINGLE, TICK_MAX, 1'b1);
    send_word(CMD_BUSY_WAIT, TICK_MAX, 1'b1);
    send_word(CMD_START_SINGLE, 24'd2, 1'b1);
    send_word(CMD_START_PERIOD, 24'd3, 1'b1);
    // single shot: reload, count down, fire and shut off
    send_word(CMD_TICK, '0, 1'b0);
    send_word(CMD_READ_REMAIN, '0, 1'b0);
    send_word(CMD_TICK, '0, 1'b0);
    send_word(CMD_READ_ELAPSED, '0, 1'b0);
    send_word(CMD_TICK, '0, 1'b0);
    // periodic keeps firing
    send_word(CMD_START_PERIOD, 24'd1, 1'b1);
    repeat (4) send_word(CMD_TICK, TICK_MAX, 1'b1);
    send_word(CMD_STOP, '0, 1'b0);
    // zero reload never fires
    send_word(CMD_START_SINGLE, '0, 1'b1);
    send_word(CMD_TICK, '0, 1'b0);
    // stop leaves the timer marked busy
    send_word(CMD_STOP, '0, 1'b1);
    send_word(CMD_START_SINGLE, 24'd4, 1'b1);
    send_word(CMD_BUSY_WAIT, 24'd1, 1'b0);
    send_word(CMD_TICK, '0, 1'b0);
    send_word(CMD_TICK, '0, 1'b0);
    send_word(CMD_READ_ELAPSED, '0, 1'b0);
  endtask

  task automatic test_random_traffic();
    int phase, goal, phase_goal, sel, t, scale;
    logic [2:0] combo;
    phase = 0;
    goal = words_sent + WORD_TARGET;
    while (words_sent < goal) begin
      // first pass walks every register combination, then favors a running timer
      if (phase < 8) combo = 3'(phase);
      else combo = rand_bit() ? 3'b011 : 3'($urandom_range(0, 7));
      set_config(combo[2], combo[1], combo[0], phase == 5);
      gaps_on = (phase % 3 != 2);
      phase_goal = words_sent + WORD_TARGET / 10;
      while (words_sent < phase_goal) begin
        scale = cur_div8 ? 8 : 1;
        t = cur_div8 ? $urandom_range(0, 5) : $urandom_range(0, 16);
        sel = $urandom_range(0, 99);
        if (sel < 40) begin
          send_word(rand_bit() ? CMD_START_PERIOD : CMD_START_SINGLE, TickWidth'(t),
                    $urandom_range(0, 9) != 0);
          tick_run($urandom_range(0, (t + 2) * scale * 2));
          if ($urandom_range(0, 9) == 0) send_word(CMD_STOP, rand_ticks(), rand_bit());
        end else if (sel < 60) begin
          send_word(CMD_BUSY_WAIT, ($urandom_range(0, 9) == 0) ? TICK_MAX : TickWidth'(t),
                    rand_bit());
          tick_run($urandom_range(0, (t + 1) * scale));
          if ($urandom_range(0, 3) == 0)
            send_word(rdt_cmd_t'($urandom_range(1, 4)), TickWidth'(t), rand_bit());
          tick_run($urandom_range(0, (t + 1) * scale));
          if ($urandom_range(0, 5) == 0) send_word(CMD_STOP, rand_ticks(), rand_bit());
        end else if (sel < 75) begin
          repeat ($urandom_range(1, 4))
            send_word(rdt_cmd_t'($urandom_range(0, 7)), rand_ticks(), rand_bit());
        end else if (sel < 85) begin
          send_word(rand_bit() ? CMD_START_PERIOD : CMD_START_SINGLE, rand_ticks(),
                    rand_bit());
          tick_run($urandom_range(0, 20));
        end else if (sel < 97) begin
          tick_run($urandom_range(1, 3 * scale));
        end else begin
          send_word(CMD_STOP, rand_ticks(), rand_bit());
        end
      end
      phase++;
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_reset_state();
    test_directed_modes();
    test_random_traffic();
    settle();
    $display("sent %0d command words (%0d acted on), %0d config writes",
             words_sent, live_words, cfg_writes);
    $display("checked %0d result words: %0d handler fires, %0d busy-wait completions",
             results_seen, fires_seen, waits_seen);
    if (err_count == 0 && pending_results.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
hw/rtl/rdt_pkg.sv
hw/rtl/rdt_in_stage.sv
hw/rtl/rdt_engine.sv
hw/rtl/rdt_out_stage.sv
hw/rtl/reload_down_timer_with_modes_core.sv
hw/rtl/rdt_checker.sv
bench/reload_down_timer_with_modes_core_tb.sv
